### src/cua_pkg.sv
// Shared types and codes for the contiguous unit allocator.
package cua_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_BAD_SIZE = 3'd1;
  localparam logic [2:0] STAT_NO_FIT   = 3'd2;
  localparam logic [2:0] STAT_NOT_HOLD = 3'd3;
  localparam logic [2:0] STAT_HOLDING  = 3'd4;

  localparam logic [1:0] CFG_FIT_MODE    = 2'd0;
  localparam logic [1:0] CFG_MIN_REQUEST = 2'd1;
  localparam logic [1:0] CFG_MAX_REQUEST = 2'd2;

  typedef struct packed {
    logic       op;
    logic [5:0] owner_id;
    logic [7:0] unit_count;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] nodes_visited;
    logic [6:0] base_unit;
    logic [6:0] small_fragments;
    logic [6:0] holder_count;
  } out_word_t;

  typedef struct packed {
    logic clr;
    logic vld;
    logic flush;
  } scan_ctl_t;

endpackage

### src/cua_ram.sv
// Generic single write port, single read port RAM with registered read.
module cua_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/cua_runs.sv
// Run tracker: folds a stream of unit owners into segment and free run statistics.
module cua_runs #(
  parameter int TOTAL_UNITS   = 128,
  parameter int MAX_PROCESSES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cua_pkg::scan_ctl_t             ctl,
  input  logic [$clog2(TOTAL_UNITS)-1:0] idx,
  input  logic [$clog2(MAX_PROCESSES+1)-1:0] own,
  input  logic [7:0]                     n_req,
  input  logic                           fit_mode,
  output logic [$clog2(TOTAL_UNITS+1)-1:0] seg_cnt,
  output logic [$clog2(TOTAL_UNITS+1)-1:0] small_cnt,
  output logic                           found,
  output logic [$clog2(TOTAL_UNITS)-1:0] pick_start,
  output logic [$clog2(TOTAL_UNITS+1)-1:0] pick_pos
);

  localparam int IW = $clog2(TOTAL_UNITS);
  localparam int LW = $clog2(TOTAL_UNITS + 1);
  localparam int OW = $clog2(MAX_PROCESSES + 1);
  localparam logic [OW-1:0] FREE_MARK = OW'(MAX_PROCESSES);

  logic          active_r;
  logic [OW-1:0] run_own_r;
  logic [IW-1:0] run_start_r;
  logic [LW-1:0] run_len_r;
  logic [LW-1:0] seg_r;
  logic [LW-1:0] small_r;
  logic          found_r;
  logic [IW-1:0] pick_start_r;
  logic [LW-1:0] pick_pos_r;
  logic [LW-1:0] best_len_r;
  logic          close;
  logic          is_free;
  logic          adequate;
  logic          take;

  always_comb begin
    close    = ctl.flush ? active_r : (ctl.vld && active_r && (own != run_own_r));
    is_free  = (run_own_r == FREE_MARK);
    adequate = is_free && (32'(run_len_r) >= 32'(n_req));
    if (fit_mode) begin
      take = adequate && (!found_r || (run_len_r < best_len_r));
    end else begin
      take = adequate && !found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      active_r <= 1'b0;
      seg_r    <= '0;
      small_r  <= '0;
      found_r  <= 1'b0;
    end else begin
      if (close) begin
        seg_r <= seg_r + LW'(1);
        if (is_free && (run_len_r == LW'(1) || run_len_r == LW'(2))) begin
          small_r <= small_r + LW'(1);
        end
        if (take) begin
          found_r      <= 1'b1;
          pick_start_r <= run_start_r;
          pick_pos_r   <= seg_r + LW'(1);
          best_len_r   <= run_len_r;
        end
      end
      if (ctl.flush) begin
        active_r <= 1'b0;
      end else if (ctl.vld) begin
        if (!active_r || own != run_own_r) begin
          active_r    <= 1'b1;
          run_own_r   <= own;
          run_start_r <= idx;
          run_len_r   <= LW'(1);
        end else begin
          run_len_r <= run_len_r + LW'(1);
        end
      end
    end
  end

  assign seg_cnt    = seg_r;
  assign small_cnt  = small_r;
  assign found      = found_r;
  assign pick_start = pick_start_r;
  assign pick_pos   = pick_pos_r;

endmodule

### src/contiguous_unit_allocator.sv
// Top level of the contiguous unit allocator: request sequencer, owner and holder memories.
// After reset the block marks every unit free in turn and stays busy until it is done.
// Every request ends in a counting scan of the owner memory; before it, a free reads the
// holder memory and writes the freed units, and an allocate runs a fit scan and, if a
// fitting run is found, writes its units. A rejected request runs only the counting scan.
// Each scan walks the single owner memory read port one unit per cycle. The one result
// word appears on out_data with out_strobe, which is high for a single cycle, and cannot
// be held off.
module contiguous_unit_allocator #(
  parameter int TOTAL_UNITS   = 128,
  parameter int MAX_PROCESSES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cua_pkg::in_word_t  in_data,
  output logic               out_strobe,
  output cua_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  localparam int IW = $clog2(TOTAL_UNITS);
  localparam int LW = $clog2(TOTAL_UNITS + 1);
  localparam int OW = $clog2(MAX_PROCESSES + 1);
  localparam int PW = $clog2(MAX_PROCESSES);
  localparam int HW = $clog2(MAX_PROCESSES + 1);
  localparam logic [OW-1:0] FREE_MARK = OW'(MAX_PROCESSES);
  localparam logic [IW:0]   UNITS     = (IW + 1)'(TOTAL_UNITS);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_HRD  = 4'd2;
  localparam logic [3:0] S_FIND = 4'd3;
  localparam logic [3:0] S_DEC  = 4'd4;
  localparam logic [3:0] S_WR   = 4'd5;
  localparam logic [3:0] S_CNT  = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0]               state_r;
  logic [IW:0]              cnt_r;
  logic [7:0]               wrem_r;
  logic                     rdv_r;
  logic [IW-1:0]            ridx_r;
  logic                     clr_r;
  logic                     op_r;
  logic [5:0]               pid_r;
  logic [7:0]               n_r;
  logic [2:0]               status_r;
  logic [7:0]               nodes_r;
  logic [IW-1:0]            start_r;
  logic [HW-1:0]            holders_r;
  logic [MAX_PROCESSES-1:0] hvalid_r;
  logic                     fit_r;
  logic [7:0]               min_r;
  logic [7:0]               max_r;
  logic                     out_strobe_r;
  cua_pkg::out_word_t       out_data_r;

  logic                     accept;
  logic [PW-1:0]            in_pidx;
  logic [PW-1:0]            pidx;
  logic                     in_oor;
  logic                     bad_size;
  logic                     scanning;
  logic                     flush;
  logic                     o_we;
  logic [OW-1:0]            o_wdata;
  logic                     o_re;
  logic [OW-1:0]            o_rdata;
  logic                     h_we;
  logic [IW+7:0]            h_rdata;
  cua_pkg::scan_ctl_t       sctl;
  logic [LW-1:0]            seg_cnt;
  logic [LW-1:0]            small_cnt;
  logic                     found;
  logic [IW-1:0]            pick_start;
  logic [LW-1:0]            pick_pos;
  logic [LW-1:0]            nodes_raw;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_pidx   = PW'(in_data.owner_id);
  assign pidx      = PW'(pid_r);
  assign in_oor    = (32'(in_data.owner_id) >= 32'(MAX_PROCESSES));
  assign bad_size  = (in_data.unit_count == 8'd0)
                  || (32'(in_data.unit_count) > 32'(TOTAL_UNITS))
                  || (in_data.unit_count < min_r) || (in_data.unit_count > max_r);
  assign scanning  = (state_r == S_FIND) || (state_r == S_CNT);
  assign flush     = scanning && (cnt_r == UNITS) && !rdv_r;
  assign nodes_raw = (!fit_r && found) ? pick_pos : seg_cnt;

  always_comb begin
    o_re    = scanning && (cnt_r < UNITS);
    o_we    = (state_r == S_CLR) || ((state_r == S_WR) && (wrem_r != 8'd0) && (cnt_r < UNITS));
    o_wdata = (state_r == S_CLR || op_r == cua_pkg::OP_FREE) ? FREE_MARK : OW'(pid_r);
    h_we    = (state_r == S_DEC) && found;
    sctl.clr   = clr_r;
    sctl.vld   = rdv_r;
    sctl.flush = flush;
  end

  cua_ram #(.WIDTH(OW), .DEPTH(TOTAL_UNITS)) u_owner (
    .clk   (clk),
    .we    (o_we),
    .waddr (cnt_r[IW-1:0]),
    .wdata (o_wdata),
    .re    (o_re),
    .raddr (cnt_r[IW-1:0]),
    .rdata (o_rdata)
  );

  cua_ram #(.WIDTH(IW + 8), .DEPTH(MAX_PROCESSES)) u_holder (
    .clk   (clk),
    .we    (h_we),
    .waddr (pidx),
    .wdata ({pick_start, n_r}),
    .re    (accept),
    .raddr (in_pidx),
    .rdata (h_rdata)
  );

  cua_runs #(.TOTAL_UNITS(TOTAL_UNITS), .MAX_PROCESSES(MAX_PROCESSES)) u_runs (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (sctl),
    .idx        (ridx_r),
    .own        (o_rdata),
    .n_req      (n_r),
    .fit_mode   (fit_r),
    .seg_cnt    (seg_cnt),
    .small_cnt  (small_cnt),
    .found      (found),
    .pick_start (pick_start),
    .pick_pos   (pick_pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_r <= 1'b0;
      min_r <= 8'd3;
      max_r <= 8'd10;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cua_pkg::CFG_FIT_MODE:    fit_r <= cfg_data[0];
        cua_pkg::CFG_MIN_REQUEST: min_r <= cfg_data;
        cua_pkg::CFG_MAX_REQUEST: max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rdv_r  <= o_re;
    ridx_r <= cnt_r[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      cnt_r        <= '0;
      clr_r        <= 1'b0;
      holders_r    <= '0;
      hvalid_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      clr_r        <= 1'b0;
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          cnt_r <= cnt_r + (IW + 1)'(1);
          if (cnt_r == UNITS - (IW + 1)'(1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_r     <= in_data.op;
            pid_r    <= in_data.owner_id;
            n_r      <= in_data.unit_count;
            nodes_r  <= 8'd0;
            start_r  <= '0;
            status_r <= cua_pkg::STAT_OK;
            cnt_r    <= '0;
            clr_r    <= 1'b1;
            state_r  <= S_CNT;
            if (in_data.op == cua_pkg::OP_ALLOC) begin
              if (bad_size) begin
                status_r <= cua_pkg::STAT_BAD_SIZE;
              end else if (in_oor) begin
                status_r <= cua_pkg::STAT_NO_FIT;
              end else if (hvalid_r[in_pidx]) begin
                status_r <= cua_pkg::STAT_HOLDING;
              end else begin
                state_r <= S_FIND;
              end
            end else if (in_oor || !hvalid_r[in_pidx]) begin
              status_r <= cua_pkg::STAT_NOT_HOLD;
            end else begin
              clr_r   <= 1'b0;
              state_r <= S_HRD;
            end
          end
        end
        S_HRD: begin
          start_r        <= h_rdata[IW+7:8];
          cnt_r          <= {1'b0, h_rdata[IW+7:8]};
          wrem_r         <= h_rdata[7:0];
          hvalid_r[pidx] <= 1'b0;
          if (holders_r != '0) begin
            holders_r <= holders_r - HW'(1);
          end
          state_r <= S_WR;
        end
        S_FIND: begin
          if (o_re) begin
            cnt_r <= cnt_r + (IW + 1)'(1);
          end
          if (flush) begin
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          nodes_r <= (32'(nodes_raw) > 32'd255) ? 8'd255 : 8'(nodes_raw);
          if (!found) begin
            status_r <= cua_pkg::STAT_NO_FIT;
            cnt_r    <= '0;
            clr_r    <= 1'b1;
            state_r  <= S_CNT;
          end else begin
            start_r        <= pick_start;
            cnt_r          <= {1'b0, pick_start};
            wrem_r         <= n_r;
            hvalid_r[pidx] <= 1'b1;
            holders_r      <= holders_r + HW'(1);
            state_r        <= S_WR;
          end
        end
        S_WR: begin
          if (o_we) begin
            cnt_r  <= cnt_r + (IW + 1)'(1);
            wrem_r <= wrem_r - 8'd1;
          end else begin
            cnt_r   <= '0;
            clr_r   <= 1'b1;
            state_r <= S_CNT;
          end
        end
        S_CNT: begin
          if (o_re) begin
            cnt_r <= cnt_r + (IW + 1)'(1);
          end
          if (flush) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_strobe_r                <= 1'b1;
          out_data_r.status           <= status_r;
          out_data_r.nodes_visited    <= nodes_r;
          out_data_r.base_unit        <= 7'(start_r);
          out_data_r.small_fragments  <= 7'(small_cnt);
          out_data_r.holder_count     <= 7'(holders_r);
          state_r                     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

### dv/contiguous_unit_allocator_test.sv
// Self-checking testbench for the contiguous unit allocator with its own allocation predictor.
`timescale 1ns / 100ps

module contiguous_unit_allocator_test;

  localparam int UNITS = 128;
  localparam int IDS = 64;
  localparam logic [6:0] FREE_OWNER = 7'd64;
  localparam int SETTLE_CYCLES = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  cua_pkg::in_word_t in_data = '0;
  logic out_strobe;
  cua_pkg::out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  contiguous_unit_allocator u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  logic [6:0] owner_of[UNITS];
  logic [6:0] seg_start[IDS];
  logic [7:0] seg_size[IDS];
  logic       seg_held[IDS];
  int         holder_total;
  logic       smallest_fit;
  logic [7:0] min_units;
  logic [7:0] max_units;

  cua_pkg::in_word_t  pending_requests[$];
  cua_pkg::out_word_t expected_words[$];
  int                 gap_left;
  int                 failures;
  logic               next_start;
  cua_pkg::in_word_t  next_word;

  function automatic int run_limit(int i);
    int j;
    j = i + 1;
    while (j < UNITS && owner_of[j] == owner_of[i]) j++;
    return j;
  endfunction

  function automatic cua_pkg::out_word_t allocate_or_free(cua_pkg::in_word_t req);
    cua_pkg::out_word_t res;
    int i, j, len, seg, pos, best_len, best_at, nodes;
    logic found;
    res = '0;
    nodes = 0;
    if (req.op == cua_pkg::OP_ALLOC) begin
      if (req.unit_count == 0 || req.unit_count > UNITS || req.unit_count < min_units ||
          req.unit_count > max_units) begin
        res.status = cua_pkg::STAT_BAD_SIZE;
      end else if (seg_held[req.owner_id]) begin
        res.status = cua_pkg::STAT_HOLDING;
      end else begin
        i = 0; seg = 0; pos = 0; best_len = UNITS + 1; best_at = 0; found = 1'b0;
        while (i < UNITS) begin
          j = run_limit(i);
          len = j - i;
          seg++;
          if (owner_of[i] == FREE_OWNER && len >= req.unit_count) begin
            if (!smallest_fit) begin
              if (!found) begin
                found = 1'b1; pos = seg; best_at = i;
              end
            end else if (len < best_len) begin
              found = 1'b1; best_len = len; best_at = i;
            end
          end
          i = j;
        end
        nodes = (!smallest_fit && found) ? pos : seg;
        if (!found) begin
          res.status = cua_pkg::STAT_NO_FIT;
        end else begin
          for (int k = best_at; k < best_at + req.unit_count && k < UNITS; k++)
            owner_of[k] = {1'b0, req.owner_id};
          seg_start[req.owner_id] = best_at[6:0];
          seg_size[req.owner_id] = req.unit_count;
          seg_held[req.owner_id] = 1'b1;
          holder_total++;
          res.status = cua_pkg::STAT_OK;
          res.base_unit = best_at[6:0];
        end
      end
    end else begin
      if (!seg_held[req.owner_id]) begin
        res.status = cua_pkg::STAT_NOT_HOLD;
      end else begin
        i = seg_start[req.owner_id];
        for (int k = i; k < i + seg_size[req.owner_id] && k < UNITS; k++)
          owner_of[k] = FREE_OWNER;
        seg_held[req.owner_id] = 1'b0;
        if (holder_total > 0) holder_total--;
        res.status = cua_pkg::STAT_OK;
        res.base_unit = i[6:0];
      end
    end
    res.nodes_visited = (nodes > 255) ? 8'd255 : nodes[7:0];
    seg = 0; i = 0;
    while (i < UNITS) begin
      j = run_limit(i);
      if (owner_of[i] == FREE_OWNER && (j - i == 1 || j - i == 2)) seg++;
      i = j;
    end
    res.small_fragments = seg[6:0];
    res.holder_count = holder_total[6:0];
    return res;
  endfunction

  task automatic report(string field, int got, int want);
    $display("Mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    failures++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      next_start = start;
      next_word = in_data;
      if (start && !busy) begin
        expected_words.push_back(allocate_or_free(in_data));
        next_start = 1'b0;
        gap_left <= pick_gap();
      end else if (!start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_requests.size() > 0) begin
          next_word = pending_requests.pop_front();
          next_start = 1'b1;
        end
      end
      start <= next_start;
      in_data <= next_word;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_words.size() == 0) begin
        report("unexpected word", out_data.status, -1);
      end else begin
        cua_pkg::out_word_t want;
        want = expected_words.pop_front();
        if (out_data.status !== want.status)
          report("status", out_data.status, want.status);
        if (out_data.nodes_visited !== want.nodes_visited)
          report("nodes_visited", out_data.nodes_visited, want.nodes_visited);
        if (out_data.base_unit !== want.base_unit)
          report("base_unit", out_data.base_unit, want.base_unit);
        if (out_data.small_fragments !== want.small_fragments)
          report("small_fragments", out_data.small_fragments, want.small_fragments);
        if (out_data.holder_count !== want.holder_count)
          report("holder_count", out_data.holder_count, want.holder_count);
      end
    end
  end

  task automatic queue_request(logic op, int pid, int units);
    cua_pkg::in_word_t w;
    w.op = op;
    w.owner_id = pid[5:0];
    w.unit_count = units[7:0];
    pending_requests.push_back(w);
  endtask

  task automatic queue_random(int count);
    int r, pid, units;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      pid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15);
      if (r < 8) units = $urandom_range(0, 255);
      else if (min_units <= max_units && max_units <= UNITS)
        units = $urandom_range(min_units, max_units);
      else units = $urandom_range(1, UNITS);
      queue_request((r >= 55) ? cua_pkg::OP_FREE : cua_pkg::OP_ALLOC, pid, units);
    end
  endtask

  task automatic drain();
    while (pending_requests.size() > 0 || start || expected_words.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      cua_pkg::CFG_FIT_MODE: smallest_fit = value[0];
      cua_pkg::CFG_MIN_REQUEST: min_units = value;
      cua_pkg::CFG_MAX_REQUEST: max_units = value;
      default: ;
    endcase
  endtask

  task automatic set_limits(logic mode, int lo, int hi);
    write_register(cua_pkg::CFG_FIT_MODE, {7'd0, mode});
    write_register(cua_pkg::CFG_MIN_REQUEST, lo[7:0]);
    write_register(cua_pkg::CFG_MAX_REQUEST, hi[7:0]);
  endtask

  initial begin
    failures = 0;
    holder_total = 0;
    smallest_fit = 1'b0;
    min_units = 8'd3;
    max_units = 8'd10;
    for (int k = 0; k < UNITS; k++) owner_of[k] = FREE_OWNER;
    for (int k = 0; k < IDS; k++) seg_held[k] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Size limits, an id already holding, a free of a non-holder, and the top id.
    queue_request(cua_pkg::OP_ALLOC, 0, 3);
    queue_request(cua_pkg::OP_ALLOC, 0, 5);
    queue_request(cua_pkg::OP_ALLOC, 1, 0);
    queue_request(cua_pkg::OP_ALLOC, 1, 2);
    queue_request(cua_pkg::OP_ALLOC, 1, 11);
    queue_request(cua_pkg::OP_ALLOC, 1, 255);
    queue_request(cua_pkg::OP_ALLOC, 63, 10);
    queue_request(cua_pkg::OP_ALLOC, 2, 4);
    queue_request(cua_pkg::OP_FREE, 5, 0);
    queue_request(cua_pkg::OP_FREE, 0, 77);
    queue_request(cua_pkg::OP_ALLOC, 3, 1);
    queue_request(cua_pkg::OP_FREE, 63, 0);
    queue_request(cua_pkg::OP_ALLOC, 4, 3);
    queue_random(110);
    drain();

    set_limits(1'b1, 1, 128);
    queue_request(cua_pkg::OP_ALLOC, 40, 128);
    queue_request(cua_pkg::OP_ALLOC, 41, 129);
    queue_request(cua_pkg::OP_ALLOC, 42, 1);
    queue_random(120);
    drain();

    set_limits(1'b0, 1, 2);
    queue_random(120);
    drain();

    // Inverted limits reject every allocate.
    set_limits(1'b1, 5, 2);
    queue_request(cua_pkg::OP_ALLOC, 50, 3);
    queue_random(40);
    drain();

    set_limits(1'b1, 128, 128);
    queue_random(40);
    drain();

    set_limits(1'b0, 1, 40);
    queue_random(200);
    drain();

    set_limits(1'b1, 2, 12);
    queue_random(200);
    drain();

    if (failures == 0) begin
      $display("contiguous_unit_allocator test passed");
    end else begin
      $display("contiguous_unit_allocator test failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("contiguous_unit_allocator test failed");
    $finish;
  end

endmodule
